@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks, sampled on i_clk and held off while i_rst_n is low.
`define ASSERT_NOW(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/smpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

    localparam int CAPACITY = 64;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] timestamp;
    } t_req;

    typedef struct packed {
        logic              removed_valid;
        logic [TIME_W-1:0] removed_time;
        logic              insert_dropped;
        logic [TIME_W-1:0] head_time;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
        logic              is_full;
    } t_res;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [TIME_W-1:0] ts;
    } t_cell_op;

endpackage

`default_nettype wire

@@ rtl/sorted_min_priority_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted minimum priority queue of up to CAPACITY timestamps.
// Request channel: i_req (req_type, timestamp) is taken at a clock edge with
// start high and busy low. Insert places the timestamp behind all stored
// entries that are equal or smaller; remove takes out the smallest entry.
// Result channel: o_res is valid for exactly one cycle while o_done is high,
// registered in r_res, and o_done (r_done) rises as busy falls. Every request
// gives one result: removed value, drop flag for an insert into a full queue,
// new head, count and flags. busy is high for the cycle after a request,
// and no new request is taken then; meanwhile the cell chain shifts: each
// cell compares its entry with the timestamp and keeps it or takes its left
// neighbor's value, the new timestamp or its right neighbor's value, all cells in the same cycle.
// The receiver cannot stall; o_done is a pure strobe.
// Reset (synchronous, active low) empties the queue at once; the cell
// contents are not cleared, as occupancy follows from the entry count.
module sorted_min_priority_queue_top
    import smpq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_res      o_res
);

    `include "assert_macros.svh"

    logic             r_pend;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_res             r_res;
    t_res             n_res;
    t_cell_op         w_op;
    logic             w_full;
    logic             w_empty;

    logic [TIME_W-1:0] w_val  [CAPACITY];
    logic              w_take [CAPACITY];

    assign w_full  = r_count == CNT_W'(CAPACITY);
    assign w_empty = r_count == '0;

    assign w_op.ins = r_pend && (r_req.req_type == REQ_INSERT) && !w_full;
    assign w_op.rem = r_pend && (r_req.req_type == REQ_REMOVE) && !w_empty;
    assign w_op.ts  = r_req.timestamp;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        smpq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_count     (r_count),
            .i_idx       (CNT_W'(g)),
            .i_left_val  ((g == 0) ? '0 : w_val[(g == 0) ? 0 : g - 1]),
            .i_left_take ((g == 0) ? 1'b0 : w_take[(g == 0) ? 0 : g - 1]),
            .i_right_val ((g == CAPACITY - 1) ? '0 : w_val[(g == CAPACITY - 1) ? g : g + 1]),
            .o_val       (w_val[g]),
            .o_take      (w_take[g])
        );
    end

    always_comb begin
        n_count             = r_count;
        n_res.removed_valid = 1'b0;
        n_res.removed_time  = '0;
        n_res.insert_dropped = 1'b0;
        n_res.head_time     = w_empty ? '0 : w_val[0];
        if (r_req.req_type == REQ_INSERT) begin
            if (w_full) begin
                n_res.insert_dropped = 1'b1;
            end else begin
                n_count         = r_count + CNT_W'(1);
                n_res.head_time = w_take[0] ? r_req.timestamp : w_val[0];
            end
        end else if (!w_empty) begin
            n_count             = r_count - CNT_W'(1);
            n_res.removed_valid = 1'b1;
            n_res.removed_time  = w_val[0];
            n_res.head_time     = (r_count > CNT_W'(1)) ? w_val[1] : '0;
        end
        n_res.entry_count = n_count;
        n_res.is_empty    = n_count == '0;
        n_res.is_full     = n_count == CNT_W'(CAPACITY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_pend <= start && !r_pend;
            r_done <= r_pend;
            if (r_pend) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_pend) begin
            r_req <= i_req;
        end
        if (r_pend) begin
            r_res <= n_res;
        end
    end

    assign busy   = r_pend;
    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_NOW(a_count_bound, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_NEXT(a_done_follows, r_pend, o_done && !r_pend, "result strobe did not follow the shift")
    `ASSERT_IMPL(a_one_outcome, o_done, !(o_res.removed_valid && o_res.insert_dropped),
                 "remove and drop flagged together")
    `ASSERT_IMPL(a_count_match, o_done, o_res.entry_count == r_count,
                 "reported count differs from held count")
    `ASSERT_IMPL(a_empty_head, o_done && o_res.is_empty, o_res.head_time == '0,
                 "empty queue reports a nonzero head")

endmodule

`default_nettype wire

@@ rtl/smpq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell
    import smpq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_op          i_op,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic [CNT_W-1:0]  i_idx,
    input  wire logic [TIME_W-1:0] i_left_val,
    input  wire logic              i_left_take,
    input  wire logic [TIME_W-1:0] i_right_val,
    output logic [TIME_W-1:0]      o_val,
    output logic                   o_take
);

    logic [TIME_W-1:0] r_val;
    logic [TIME_W-1:0] n_val;
    logic              w_occ;

    assign w_occ  = i_idx < i_count;
    // Free cells and cells holding a larger value take part in the insert shift.
    assign o_take = !w_occ || (r_val > i_op.ts);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_op.ins) begin
            if (o_take) begin
                n_val = i_left_take ? i_left_val : i_op.ts;
            end
        end else if (i_op.rem) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire
